// File: rtl/rau_pkg.sv
// Shared constants and types for the rational arithmetic unit.
package rau_pkg;
    localparam int WORD_WIDTH = 32;
    localparam int DW = 2 * WORD_WIDTH;
    localparam int CW = $clog2(DW + 1);

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef logic [DW-1:0] dword_t;

    typedef struct packed {
        logic start;
        logic is_mul;
        dword_t a;
        dword_t b;
    } op_req_t;

    typedef struct packed {
        logic   done;
        dword_t q;
        dword_t r;
    } op_rsp_t;
endpackage

// File: rtl/rau_opunit.sv
// Shared bit-serial unit: 64-bit shift-add multiply or restoring divide.
module rau_opunit import rau_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  op_req_t req,
    output op_rsp_t rsp
);
    logic          busy_reg, mul_reg;
    logic [CW-1:0] cnt_reg;
    dword_t        a_reg, b_reg, acc_reg, q_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    assign trial = {acc_reg, q_reg[DW-1]} - {1'b0, b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                mul_reg  <= req.is_mul;
                cnt_reg  <= CW'(DW);
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
                q_reg    <= req.a;
            end else if (busy_reg) begin
                if (mul_reg) begin
                    if (q_reg[0]) acc_reg <= acc_reg + b_reg;
                    b_reg <= b_reg << 1;
                    q_reg <= q_reg >> 1;
                end else begin
                    if (!trial[DW]) begin
                        acc_reg <= trial[DW-1:0];
                        q_reg   <= {q_reg[DW-2:0], 1'b1};
                    end else begin
                        acc_reg <= {acc_reg[DW-2:0], q_reg[DW-1]};
                        q_reg   <= {q_reg[DW-2:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = mul_reg ? acc_reg : q_reg;
    assign rsp.r    = mul_reg ? a_reg : acc_reg;
endmodule

// File: rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: sequencer around a shared multiply/divide unit.
// An invalid operand goes straight to the output without using the shared unit;
// otherwise a beat runs 12 to about 190 shared-unit operations (at least 6 on a
// divide by zero; Euclid steps dominate).
// Throughput: one beat at a time; s_axis_tready is low until the result is taken.
// Reset: synchronous active-low aresetn clears the sequencer and output valid.
module rational_arithmetic_unit_top import rau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], lhs_num[33:2], lhs_den[65:34], rhs_num[97:66], rhs_den[129:98]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_num[31:0], res_den[62:32], status[64:63]
    output logic [71:0]  m_axis_tdata
);
    localparam logic [3:0] S_IDLE = 4'd0, S_GCD = 4'd1, S_GWAIT = 4'd2,
        S_DIVN = 4'd3, S_DIVD = 4'd4, S_NEXT = 4'd5, S_M1 = 4'd6, S_M2 = 4'd7,
        S_M3 = 4'd8, S_COMB = 4'd9, S_M3W = 4'd10, S_OUT = 4'd11,
        S_DIVNW = 4'd12, S_DIVDW = 4'd13, S_M1W = 4'd14, S_M2W = 4'd15;

    localparam logic [1:0] PH_LHS = 2'd0, PH_RHS = 2'd1, PH_RES = 2'd2;

    localparam dword_t TOP = dword_t'(1) << (WORD_WIDTH - 1);

    logic [3:0] state_reg;
    logic [1:0] phase_reg;
    logic [1:0] func_reg;
    dword_t an_reg, ad_reg, bn_reg, bd_reg, p_reg, q_reg, rd_reg;
    logic   as_reg, bs_reg, rs_reg, ns_reg;
    dword_t n_reg, d_reg, x_reg, y_reg, g_reg;
    logic [31:0] on_reg;
    logic [30:0] od_reg;
    logic [1:0]  ost_reg;
    logic        ovalid_reg;
    logic        same_sign;
    dword_t      comb_mag;
    logic        comb_neg;
    op_req_t req;
    op_rsp_t rsp;

    rau_opunit u_op (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    function automatic dword_t mag(input logic [31:0] raw);
        logic [WORD_WIDTH-1:0] v;
        logic [WORD_WIDTH-1:0] m;
        v = raw[WORD_WIDTH-1:0];
        m = v[WORD_WIDTH-1] ? (~v + 1'b1) : v;
        return dword_t'(m);
    endfunction

    function automatic logic sgn(input logic [31:0] raw);
        return raw[WORD_WIDTH-1];
    endfunction

    always_comb begin
        req = '0;
        unique case (state_reg)
            S_GCD:  begin req.start = (y_reg != '0); req.a = x_reg; req.b = y_reg; end
            S_DIVN: begin req.start = 1'b1; req.a = n_reg; req.b = g_reg; end
            S_DIVD: begin req.start = 1'b1; req.a = d_reg; req.b = g_reg; end
            S_M1:   begin
                req.start = 1'b1; req.is_mul = 1'b1; req.a = an_reg;
                req.b = func_reg[1] ? bn_reg : bd_reg;
            end
            S_M2:   begin
                req.start = 1'b1; req.is_mul = 1'b1; req.a = bn_reg; req.b = ad_reg;
            end
            S_M3:   begin
                req.start = 1'b1; req.is_mul = 1'b1; req.a = ad_reg; req.b = bd_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        same_sign = as_reg == (bs_reg ^ (func_reg == FUNC_SUB));
        if (func_reg[1]) begin
            comb_mag = p_reg; comb_neg = as_reg != bs_reg;
        end else if (same_sign) begin
            comb_mag = p_reg + q_reg; comb_neg = as_reg;
        end else if (p_reg >= q_reg) begin
            comb_mag = p_reg - q_reg; comb_neg = as_reg;
        end else begin
            comb_mag = q_reg - p_reg; comb_neg = ~as_reg;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            phase_reg  <= PH_LHS;
        end else begin
            if (state_reg == S_OUT) ovalid_reg <= 1'b1;
            else if (ovalid_reg && m_axis_tready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    func_reg <= s_axis_tdata[1:0];
                    an_reg <= mag(s_axis_tdata[33:2]);   as_reg <= sgn(s_axis_tdata[33:2]);
                    ad_reg <= mag(s_axis_tdata[65:34]);  ns_reg <= sgn(s_axis_tdata[65:34]);
                    bn_reg <= mag(s_axis_tdata[97:66]);  bs_reg <= sgn(s_axis_tdata[97:66]);
                    bd_reg <= mag(s_axis_tdata[129:98]); rs_reg <= sgn(s_axis_tdata[129:98]);
                    on_reg <= '0; od_reg <= 31'd1;
                    if (mag(s_axis_tdata[65:34]) == '0 || mag(s_axis_tdata[129:98]) == '0) begin
                        ost_reg <= ST_INVALID; state_reg <= S_OUT;
                    end else begin
                        ost_reg <= ST_OK; phase_reg <= PH_LHS;
                        n_reg <= mag(s_axis_tdata[33:2]); d_reg <= mag(s_axis_tdata[65:34]);
                        x_reg <= mag(s_axis_tdata[33:2]); y_reg <= mag(s_axis_tdata[65:34]);
                        state_reg <= S_GCD;
                    end
                end
                S_GCD: if (y_reg == '0) begin
                    g_reg <= x_reg; state_reg <= S_DIVN;
                end else state_reg <= S_GWAIT;
                S_GWAIT: if (rsp.done) begin
                    x_reg <= y_reg; y_reg <= rsp.r; state_reg <= S_GCD;
                end
                S_DIVN: state_reg <= S_DIVNW;
                S_DIVNW: if (rsp.done) begin
                    n_reg <= rsp.q; state_reg <= S_DIVD;
                end
                S_DIVD: state_reg <= S_DIVDW;
                S_DIVDW: if (rsp.done) begin
                    d_reg <= rsp.q; state_reg <= S_NEXT;
                end
                S_NEXT: begin
                    unique case (phase_reg)
                        PH_LHS: begin
                            an_reg <= n_reg; ad_reg <= d_reg;
                            as_reg <= (n_reg != '0) && (as_reg != ns_reg);
                            phase_reg <= PH_RHS;
                            n_reg <= bn_reg; d_reg <= bd_reg; x_reg <= bn_reg; y_reg <= bd_reg;
                            state_reg <= S_GCD;
                        end
                        PH_RHS: begin
                            bs_reg <= (n_reg != '0) && (bs_reg != rs_reg);
                            if (func_reg == FUNC_DIV) begin
                                if (n_reg == '0) begin
                                    ost_reg <= ST_DIVZERO; state_reg <= S_OUT;
                                end else begin
                                    bn_reg <= d_reg; bd_reg <= n_reg; state_reg <= S_M1;
                                end
                            end else begin
                                bn_reg <= n_reg; bd_reg <= d_reg; state_reg <= S_M1;
                            end
                        end
                        default: begin
                            if (d_reg > TOP - 1) ost_reg <= ST_OVERFLOW;
                            else if ((n_reg != '0 && rs_reg) ? (n_reg > TOP) : (n_reg > TOP - 1))
                                ost_reg <= ST_OVERFLOW;
                            else begin
                                on_reg <= 32'((n_reg != '0 && rs_reg) ? -n_reg : n_reg);
                                od_reg <= d_reg[30:0];
                            end
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_M1: state_reg <= S_M1W;
                S_M1W: if (rsp.done) begin
                    p_reg <= rsp.q; state_reg <= S_M2;
                end
                S_M2: state_reg <= S_M2W;
                S_M2W: if (rsp.done) begin
                    q_reg <= rsp.q; state_reg <= S_M3;
                end
                S_M3: state_reg <= S_M3W;
                S_M3W: if (rsp.done) begin
                    rd_reg <= rsp.q; state_reg <= S_COMB;
                end
                S_COMB: begin
                    n_reg <= comb_mag; x_reg <= comb_mag; rs_reg <= comb_neg;
                    d_reg <= rd_reg; y_reg <= rd_reg;
                    phase_reg <= PH_RES; state_reg <= S_GCD;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, ost_reg, od_reg, on_reg};

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[64:63] == ST_OK) |-> (m_axis_tdata[62:32] != '0))
        else $error("zero denominator on ok result");
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[64:63] != ST_OK) |-> (m_axis_tdata[62:0] == 63'h1_0000_0000))
        else $error("error result not 0/1");
`endif
endmodule

// File: sim/rational_arithmetic_unit_top_tb.sv
// Testbench for the rational arithmetic unit: queue-fed driver, monitor, inline predictor.
module rational_arithmetic_unit_top_tb import rau_pkg::*; ();

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] lhs_num;
        logic [31:0] lhs_den;
        logic [31:0] rhs_num;
        logic [31:0] rhs_den;
    } frac_op_t;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  status;
    } frac_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;

    frac_op_t  pending_ops[$];
    frac_res_t expected_fracs[$];
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    bit        sink_hold = 1'b0;
    bit        src_pause = 1'b0;
    int        errors = 0;
    int        quiet_cycles = 0;

    rational_arithmetic_unit_top u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic void split_word(logic [31:0] v, output bit neg,
                                       output longint unsigned mag);
        neg = v[31];
        mag = v[31] ? longint'(33'h1_0000_0000 - {1'b0, v}) : longint'(v);
    endfunction

    function automatic frac_res_t compute_fraction(frac_op_t op);
        frac_res_t r;
        bit an_s, ad_s, bn_s, bd_s, as, bs, rs, ps, qs;
        longint unsigned an, ad, bn, bd, g, t, p, q, rn, rd;
        r.num = '0;
        r.den = 31'd1;
        split_word(op.lhs_num, an_s, an);
        split_word(op.lhs_den, ad_s, ad);
        split_word(op.rhs_num, bn_s, bn);
        split_word(op.rhs_den, bd_s, bd);
        if (ad == 0 || bd == 0) begin
            r.status = ST_INVALID;
            return r;
        end
        g = gcd64(an, ad); an /= g; ad /= g; as = (an != 0) && (an_s != ad_s);
        g = gcd64(bn, bd); bn /= g; bd /= g; bs = (bn != 0) && (bn_s != bd_s);
        if (op.func == FUNC_DIV) begin
            if (bn == 0) begin
                r.status = ST_DIVZERO;
                return r;
            end
            t = bn; bn = bd; bd = t;
        end
        if (op.func == FUNC_MUL || op.func == FUNC_DIV) begin
            rn = an * bn;
            rs = as != bs;
        end else begin
            p = an * bd;
            q = bn * ad;
            ps = as;
            qs = (op.func == FUNC_SUB) ? !bs : bs;
            if (ps == qs) begin rn = p + q; rs = ps; end
            else if (p >= q) begin rn = p - q; rs = ps; end
            else begin rn = q - p; rs = qs; end
        end
        rd = ad * bd;
        g = gcd64(rn, rd); rn /= g; rd /= g; rs = rs && (rn != 0);
        if (rd > 64'h7FFF_FFFF || (rs ? rn > 64'h8000_0000 : rn > 64'h7FFF_FFFF)) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.num = rs ? 32'(-rn) : 32'(rn);
        r.den = 31'(rd);
        r.status = ST_OK;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_ops.size() > 0 && !src_pause &&
                    $urandom_range(99, 0) >= src_idle_pct) begin
                s_axis_tdata  <= {6'd0, pending_ops[0].rhs_den, pending_ops[0].rhs_num,
                                  pending_ops[0].lhs_den, pending_ops[0].lhs_num,
                                  pending_ops[0].func};
                expected_fracs.push_back(compute_fraction(pending_ops.pop_front()));
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        frac_res_t got, exp_r;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[62:32], m_axis_tdata[64:63]};
                if (expected_fracs.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_fracs.pop_front();
                    if (got.num !== exp_r.num || got.den !== exp_r.den ||
                            got.status !== exp_r.status) begin
                        $display("%0t: mismatch expected %h/%h st %0d actual %h/%h st %0d",
                                 $time, exp_r.num, exp_r.den, exp_r.status,
                                 got.num, got.den, got.status);
                        errors <= errors + 1;
                    end
                end
            end
            m_axis_tready <= !sink_hold && $urandom_range(99, 0) >= snk_idle_pct;
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles > 200000) begin
            $display("rational_arithmetic_unit_top_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5, 0))
            0: return 32'($signed($urandom_range(20, 0)) - 10);
            1: return 32'($urandom_range(1000, 0));
            2: return {$urandom_range(1, 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [1:0] f, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c, logic [31:0] d);
        frac_op_t op;
        op = '{f, a, b, c, d};
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || expected_fracs.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
    endtask

    initial begin
        frac_op_t op;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        for (int f = 0; f < 4; f++) begin
            add_op(2'(f), 32'd1, 32'd2, 32'd1, 32'd3);
            add_op(2'(f), 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1);
            add_op(2'(f), 32'd0, 32'd5, 32'hFFFF_FFFD, 32'hFFFF_FFFA);
        end
        add_op(FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        add_op(FUNC_DIV, 32'd1, 32'd1, 32'd1, 32'd0);
        add_op(FUNC_DIV, 32'd3, 32'd7, 32'd0, 32'd9);
        add_op(FUNC_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        add_op(FUNC_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
        add_op(FUNC_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        add_op(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        src_idle_pct = 21;
        snk_idle_pct = 67;
        for (int ph = 0; ph < 3; ph++) begin
            for (int i = 0; i < 135; i++) begin
                op.func    = 2'($urandom);
                op.lhs_num = rand_word();
                op.lhs_den = rand_word();
                op.rhs_num = rand_word();
                op.rhs_den = rand_word();
                pending_ops.push_back(op);
            end
            if (ph == 0) begin
                // long sink stall while source keeps offering
                repeat (20) @(posedge aclk);
                sink_hold = 1'b1;
                repeat (20000) @(posedge aclk);
                sink_hold = 1'b0;
            end
            wait_drained();
            src_pause = 1'b1;
            repeat (50) @(posedge aclk);
            src_pause = 1'b0;
            src_idle_pct = (ph == 0) ? 67 : 0;
            snk_idle_pct = (ph == 0) ? 21 : 0;
        end
        wait_drained();
        repeat (5000) @(posedge aclk);
        if (errors == 0 && expected_fracs.size() == 0)
            $display("rational_arithmetic_unit_top_tb: done, clean");
        else
            $display("rational_arithmetic_unit_top_tb: done, errors");
        $finish;
    end
endmodule
